FILE: hdl/bbs_pkg.sv
// Shared types, constants and register codes of the 3x3 box blur stream.
`default_nettype none
package bbs_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int KERNEL_SIZE   = 3;
   localparam int QUEUE_DEPTH   = 2;

   localparam int CFG_W      = 11;
   localparam int WGT_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int PROD_W     = 16;
   localparam int ACC_W      = 20;
   localparam int TOT_W      = 12;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_TOP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_MID   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_BOT   = 3'd4;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [WGT_W-1:0] WEIGHT_RESET = 24'h010101;

   typedef logic [7:0] pixel_type;

   // [row][column], row 0 is the top, column 0 the left
   typedef pixel_type [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] window_type;

   typedef logic [KERNEL_SIZE-1:0][WGT_W-1:0] weights_type;

   typedef struct packed {
      window_type win;
      logic       row_end;
      logic       frame_end;
   } job_type;

endpackage
`default_nettype wire

FILE: hdl/bbs_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module bbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/bbs_front.sv
// Front end: accepts pixels, keeps line stores, window and counters, issues filter jobs.
`default_nettype none
module bbs_front #(
   parameter int MAX_WIDTH = bbs_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire logic                     req_func,
   input  wire bbs_pkg::pixel_type       req_pixel_in,
   input  wire logic [bbs_pkg::CFG_W-1:0] image_width,
   input  wire logic [bbs_pkg::CFG_W-1:0] image_height,
   input  wire logic                     queue_full,
   output logic                          job_push,
   output bbs_pkg::job_type              job
);
   import bbs_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int ORW = $clog2(MAX_HEIGHT);

   logic                 run_ff, run_in;
   logic                 func_ff, func_in;
   pixel_type            pix_ff, pix_in;
   logic [CW-1:0]        in_col_ff, in_col_in;
   logic [CFG_W-1:0]     in_row_ff, in_row_in;
   logic [CW-1:0]        out_col_ff, out_col_in;
   logic [ORW-1:0]       out_row_ff, out_row_in;
   window_type           win_ff, win_in;

   logic [WW-1:0]        width_raw, w_eff;
   logic [CFG_W-1:0]     h_eff;
   logic                 accept, drop, wrap_pre;
   logic [CW-1:0]        col_pre;
   logic [CFG_W-1:0]     row_pre;

   logic [15:0]          ram_rd_data;
   pixel_type            upper_raw, lower_raw, px, a_px, b_px;
   logic                 col_zero, emitting, wrap_post, row_end, frame_end;
   logic [CW:0]          col_inc;
   logic [WW-1:0]        oc_inc;
   logic [CFG_W-1:0]     or_inc;
   window_type           shifted, padded, win_next;

   // effective frame size
   always_comb begin
      width_raw = WW'(image_width);
      if (width_raw == '0) begin
         w_eff = WW'(1);
      end else if (width_raw > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = width_raw;
      end
      if (image_height == '0) begin
         h_eff = CFG_W'(1);
      end else if (image_height > CFG_W'(MAX_HEIGHT)) begin
         h_eff = CFG_W'(MAX_HEIGHT);
      end else begin
         h_eff = image_height;
      end
   end

   assign req_full = run_ff | queue_full;
   assign accept   = req_push & ~req_full;
   assign drop     = req_func ? (in_row_ff < h_eff) : (in_row_ff >= h_eff);
   assign wrap_pre = WW'(in_col_ff) >= w_eff;
   assign col_pre  = wrap_pre ? '0 : in_col_ff;
   assign row_pre  = (wrap_pre && in_row_ff != '1) ? in_row_ff + CFG_W'(1) : in_row_ff;

   bbs_ram #(
      .WIDTH (16),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (run_ff),
      .wr_addr (in_col_ff),
      .wr_data ({lower_raw, px}),
      .rd_en   (accept & ~drop),
      .rd_addr (col_pre),
      .rd_data (ram_rd_data)
   );

   assign upper_raw = ram_rd_data[15:8];
   assign lower_raw = ram_rd_data[7:0];

   always_comb begin
      px        = func_ff ? '0 : pix_ff;
      a_px      = (in_row_ff >= CFG_W'(2)) ? upper_raw : '0;
      b_px      = (in_row_ff >= CFG_W'(1)) ? lower_raw : '0;
      col_zero  = (in_col_ff == '0);
      emitting  = (in_row_ff >= CFG_W'(2)) || ((in_row_ff >= CFG_W'(1)) && !col_zero);

      for (int r = 0; r < KERNEL_SIZE; r++) begin
         shifted[r][0]  = win_ff[r][1];
         shifted[r][1]  = win_ff[r][2];
         padded[r][0]   = win_ff[r][1];
         padded[r][1]   = win_ff[r][2];
         padded[r][2]   = '0;
         win_next[r][0] = col_zero ? '0 : win_ff[r][1];
         win_next[r][1] = col_zero ? '0 : win_ff[r][2];
      end
      shifted[0][2]  = a_px;
      shifted[1][2]  = b_px;
      shifted[2][2]  = px;
      win_next[0][2] = a_px;
      win_next[1][2] = b_px;
      win_next[2][2] = px;

      col_inc   = {1'b0, in_col_ff} + (CW + 1)'(1);
      wrap_post = WW'(col_inc) >= w_eff;
      oc_inc    = WW'(out_col_ff) + WW'(1);
      or_inc    = CFG_W'(out_row_ff) + CFG_W'(1);
      row_end   = oc_inc >= w_eff;
      frame_end = row_end && (or_inc >= h_eff);
   end

   assign job_push      = run_ff & emitting;
   assign job.win       = col_zero ? padded : shifted;
   assign job.row_end   = row_end;
   assign job.frame_end = frame_end;

   always_comb begin
      run_in     = run_ff;
      func_in    = func_ff;
      pix_in     = pix_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      win_in     = win_ff;
      if (run_ff) begin
         run_in = 1'b0;
         win_in = win_next;
         if (wrap_post) begin
            in_col_in = '0;
            if (in_row_ff != '1) begin
               in_row_in = in_row_ff + CFG_W'(1);
            end
         end else begin
            in_col_in = col_inc[CW-1:0];
         end
         if (emitting) begin
            if (row_end) begin
               out_col_in = '0;
               if (out_row_ff != '1) begin
                  out_row_in = out_row_ff + ORW'(1);
               end
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
            if (frame_end) begin
               // restart the frame
               win_in     = '0;
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
         end
      end else if (accept && !drop) begin
         run_in    = 1'b1;
         func_in   = req_func;
         pix_in    = req_pixel_in;
         in_col_in = col_pre;
         in_row_in = row_pre;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      pix_ff  <= pix_in;
      if (reset) begin
         run_ff     <= 1'b0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         win_ff     <= '0;
      end else begin
         run_ff     <= run_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         win_ff     <= win_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/bbs_queue.sv
// Short job queue between the front end and the filter back end.
`default_nettype none
module bbs_queue #(
   parameter int DEPTH = bbs_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bbs_pkg::job_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output bbs_pkg::job_type      head
);
   import bbs_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   job_type         slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == NW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/bbs_back.sv
// Back end: weighted sum, bit-serial floor division and the result register.
`default_nettype none
module bbs_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bbs_pkg::weights_type weights,
   input  wire logic                 q_empty,
   input  wire bbs_pkg::job_type     q_head,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output bbs_pkg::pixel_type        rsp_pixel_out,
   output logic                      rsp_row_end,
   output logic                      rsp_frame_end
);
   import bbs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [PROD_W-1:0] prod_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic [PROD_W-1:0] prod_in [KERNEL_SIZE][KERNEL_SIZE];
   logic              row_end_ff, row_end_in;
   logic              frame_end_ff, frame_end_in;
   logic [TOT_W-1:0]  tot_ff, tot_in;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [ACC_W-1:0]  dvs_ff, dvs_in;
   logic [2:0]        step_ff, step_in;
   pixel_type         quo_ff, quo_in;
   logic              out_valid_ff, out_valid_in;
   pixel_type         out_pix_ff, out_pix_in;
   logic              out_row_end_ff, out_row_end_in;
   logic              out_frame_end_ff, out_frame_end_in;

   logic [TOT_W-1:0]  tot_sum;
   logic [ACC_W-1:0]  acc_sum;
   logic              ge, load_out;

   always_comb begin
      tot_sum = '0;
      acc_sum = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            prod_in[r][c] = PROD_W'(weights[r][8*c +: 8]) * PROD_W'(q_head.win[r][c]);
            tot_sum       = tot_sum + TOT_W'(weights[r][8*c +: 8]);
            acc_sum       = acc_sum + ACC_W'(prod_ff[r][c]);
         end
      end
   end

   assign q_pop    = (state_ff == ST_IDLE) & ~q_empty;
   assign ge       = rem_ff >= dvs_ff;
   assign load_out = (state_ff == ST_OUT) & (~out_valid_ff | rsp_pop);

   always_comb begin
      state_in         = state_ff;
      row_end_in       = row_end_ff;
      frame_end_in     = frame_end_ff;
      tot_in           = tot_ff;
      rem_in           = rem_ff;
      dvs_in           = dvs_ff;
      step_in          = step_ff;
      quo_in           = quo_ff;
      out_pix_in       = out_pix_ff;
      out_row_end_in   = out_row_end_ff;
      out_frame_end_in = out_frame_end_ff;
      out_valid_in     = out_valid_ff & ~rsp_pop;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               row_end_in   = q_head.row_end;
               frame_end_in = q_head.frame_end;
               state_in     = ST_SUM;
            end
         end
         ST_SUM: begin
            tot_in   = tot_sum;
            rem_in   = acc_sum;
            dvs_in   = ACC_W'({tot_sum, 7'b0});
            step_in  = '1;
            quo_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit per cycle, most significant first
            if (ge) begin
               rem_in = rem_ff - dvs_ff;
            end
            quo_in  = {quo_ff[6:0], ge};
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff - 3'd1;
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               out_pix_in       = (tot_ff == '0) ? '0 : quo_ff;
               out_row_end_in   = row_end_ff;
               out_frame_end_in = frame_end_ff;
               out_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         prod_ff <= prod_in;
      end
      row_end_ff       <= row_end_in;
      frame_end_ff     <= frame_end_in;
      tot_ff           <= tot_in;
      rem_ff           <= rem_in;
      dvs_ff           <= dvs_in;
      step_ff          <= step_in;
      quo_ff           <= quo_in;
      out_pix_ff       <= out_pix_in;
      out_row_end_ff   <= out_row_end_in;
      out_frame_end_ff <= out_frame_end_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty     = ~out_valid_ff;
   assign rsp_pixel_out = out_pix_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

endmodule
`default_nettype wire

FILE: hdl/box_blur_3x3_stream.sv
// Top level of the 3x3 weighted box blur stream with zero padding.
// Path: a result passes from the transaction that completes it through the line RAM
//   read and write steps, the job queue, the sum and divide states and the result register.
// Pacing: the front end takes no new transaction while one is in flight (line RAM read,
//   then write); the back end takes a new job only when idle (sum plus 8-step divider).
// Reset: synchronous; clears counters, window, queue and result register and restores
//   the default registers. Line RAM contents are not cleared and need no clearing pass.
`default_nettype none
module box_blur_3x3_stream #(
   parameter int MAX_WIDTH = bbs_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_func,
   input  wire logic [7:0]                    req_pixel_in,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [7:0]                         rsp_pixel_out,
   output logic                               rsp_row_end,
   output logic                               rsp_frame_end,
   input  wire logic                          csr_wr_en,
   input  wire logic [bbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bbs_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import bbs_pkg::*;

   // configuration registers
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   weights_type      weights_ff, weights_in;

   // front end to queue, queue to back end
   logic             job_push;
   job_type          job;
   logic             queue_full;
   logic             queue_empty;
   logic             queue_pop;
   job_type          queue_head;

   // decode register writes; unknown indexes drop silently
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      weights_in = weights_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in      = csr_wr_data[CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_in     = csr_wr_data[CFG_W-1:0];
            REG_WEIGHT_TOP:   weights_in[0] = csr_wr_data[WGT_W-1:0];
            REG_WEIGHT_MID:   weights_in[1] = csr_wr_data[WGT_W-1:0];
            REG_WEIGHT_BOT:   weights_in[2] = csr_wr_data[WGT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         weights_ff <= {WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET};
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         weights_ff <= weights_in;
      end
   end

   // Front end: hold off new transactions while a pixel is in flight or the queue is full;
   // advance the raster counters and line stores, push one job per emitted pixel.
   bbs_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_func     (req_func),
      .req_pixel_in (req_pixel_in),
      .image_width  (width_ff),
      .image_height (height_ff),
      .queue_full   (queue_full),
      .job_push     (job_push),
      .job          (job)
   );

   // Decouple the two halves so a stalled result port does not stop pixel intake at once.
   bbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   // Back end: weight the window, divide by the weight sum, hold the result until popped.
   bbs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .weights       (weights_ff),
      .q_empty       (queue_empty),
      .q_head        (queue_head),
      .q_pop         (queue_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

FILE: tb/box_blur_3x3_stream_tb.sv
// Self-checking testbench for the streaming 3x3 weighted box blur with zero padding.
`timescale 1ns / 1ps
module box_blur_3x3_stream_tb;
   import bbs_pkg::*;

   // Request codes: a frame pixel, or a drain step that flushes the bottom padding row.
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam int STORE_DEPTH   = MAX_WIDTH_DEF;
   localparam int SETTLE_CYCLES = 24;     // lets the front end, queue and back end empty, with margin
   localparam int DRAIN_LIMIT   = 20000;  // give up on missing results after this many cycles
   localparam int RANDOM_PIXELS = 1400;

   typedef struct packed {
      pixel_type pixel;
      logic      row_end;
      logic      frame_end;
   } blur_out_type;

   typedef enum int {PAT_RANDOM, PAT_BLACK, PAT_WHITE, PAT_CHECKER, PAT_RAMP} pattern_type;
   typedef enum int {SINK_FREE, SINK_COIN, SINK_PERIODIC, SINK_SPARSE} sink_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_func = FUNC_PIXEL;
   logic [7:0]            req_pixel_in = 8'd0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [7:0]            rsp_pixel_out;
   logic                  rsp_row_end;
   logic                  rsp_frame_end;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   box_blur_3x3_stream dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_pixel_in  (req_pixel_in),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: registers, two line stores, the 3x3 window and the
   // input/output raster counters.
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] size_width;
   logic [CFG_W-1:0] size_height;
   logic [WGT_W-1:0] wt_row [KERNEL_SIZE];
   pixel_type        upper_line [STORE_DEPTH];
   pixel_type        lower_line [STORE_DEPTH];
   window_type       blur_win;
   int unsigned      in_col, in_row, out_col, out_row;

   blur_out_type pending_outputs [$];  // blurred pixels still owed by the block
   bit          frame_closed;          // set when the frame_end output has been predicted
   int unsigned accepted_pixels;       // frame pixels that the block used (ignored ones excluded)
   int unsigned pattern_index;
   int          fault_count;

   // Sender pacing and receiver hold-off control.
   bit          pace_enabled = 1'b1;
   int unsigned burst_left;
   int unsigned pop_hold_request;

   function automatic int unsigned active_width();
      int unsigned w;
      w = 32'(size_width);
      if (w == 0) w = 1;
      if (w > STORE_DEPTH) w = STORE_DEPTH;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = 32'(size_height);
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic void restart_raster();
      blur_win = '0;
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
   endfunction

   function automatic void blur_reset();
      size_width  = WIDTH_RESET;
      size_height = HEIGHT_RESET;
      for (int i = 0; i < KERNEL_SIZE; i++) wt_row[i] = WEIGHT_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      restart_raster();
   endfunction

   // Floored weighted mean of one window; a zero weight total gives zero.
   function automatic pixel_type weighted_mean(input window_type px_win);
      int unsigned acc, total, k;
      acc   = 0;
      total = 0;
      for (int u = 0; u < KERNEL_SIZE; u++) begin
         for (int v = 0; v < KERNEL_SIZE; v++) begin
            k = 32'(wt_row[u][8*v +: 8]);
            acc += k * px_win[u][v];
            total += k;
         end
      end
      if (total == 0) return '0;
      return pixel_type'(acc / total);
   endfunction

   // Advance the predictor by one accepted transaction and queue the output it causes.
   function automatic void blur_step(input logic func, input pixel_type px_in);
      int unsigned w_eff, h_eff, col;
      pixel_type   px, above2, above1, value;
      window_type  shifted;
      logic        emitting;
      blur_out_type res;
      w_eff = active_width();
      h_eff = active_height();
      // Drop pixels once the frame is complete and drains while it is still open.
      if (func == FUNC_PIXEL && in_row >= h_eff) return;
      if (func == FUNC_DRAIN && in_row < h_eff) return;
      px = (func == FUNC_DRAIN) ? 8'd0 : px_in;
      if (func == FUNC_PIXEL) accepted_pixels++;

      // Wrap first if the width shrank below the current column.
      if (in_col >= w_eff) begin
         in_col = 0;
         if (in_row < 2047) in_row++;
      end
      col = in_col % STORE_DEPTH;

      above2 = (in_row >= 2) ? upper_line[col] : 8'd0;
      above1 = (in_row >= 1) ? lower_line[col] : 8'd0;
      upper_line[col] = lower_line[col];
      lower_line[col] = px;

      emitting = (in_row >= 2) || (in_row >= 1 && in_col >= 1);
      value    = '0;
      if (in_col == 0) begin
         // Close the previous row with a zero column of right padding.
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            shifted[r][0] = blur_win[r][1];
            shifted[r][1] = blur_win[r][2];
            shifted[r][2] = 8'd0;
         end
         if (emitting) value = weighted_mean(shifted);
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            blur_win[r][0] = 8'd0;
            blur_win[r][1] = 8'd0;
         end
      end else begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            blur_win[r][0] = blur_win[r][1];
            blur_win[r][1] = blur_win[r][2];
         end
      end
      blur_win[0][2] = above2;
      blur_win[1][2] = above1;
      blur_win[2][2] = px;
      if (in_col != 0 && emitting) value = weighted_mean(blur_win);

      in_col++;
      if (in_col >= w_eff) begin
         in_col = 0;
         if (in_row < 2047) in_row++;
      end

      if (emitting) begin
         res.pixel     = value;
         res.row_end   = (out_col + 1 >= w_eff);
         res.frame_end = res.row_end && (out_row + 1 >= h_eff);
         pending_outputs.push_back(res);
         if (res.row_end) begin
            out_col = 0;
            if (out_row < 1023) out_row++;
         end else begin
            out_col++;
         end
         if (res.frame_end) begin
            restart_raster();
            frame_closed = 1'b1;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offer one transaction and hold it until accepted. Push stays high on
   // return so back-to-back items need no second assignment in a time step.
   task automatic send_item(input logic func, input pixel_type px);
      int unsigned gap;
      if (pace_enabled) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_push     <= 1'b1;
      req_func     <= func;
      req_pixel_in <= px;
      @(posedge clock);
      while (req_full) @(posedge clock);
      blur_step(func, px);
   endtask

   // Drop push, wait until every owed output has arrived, then let the
   // pipeline settle so items that cause no output are finished too.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_push <= 1'b0;
      while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_outputs.size() != 0) begin
         $display("%0t: %0d expected outputs never arrived", $time, pending_outputs.size());
         fault_count++;
         pending_outputs.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = value;
      // Size registers use the low bits only; toggle the rest anyway.
      if (index == REG_IMAGE_WIDTH || index == REG_IMAGE_HEIGHT)
         data[CSR_DATA_W-1:CFG_W] = (CSR_DATA_W - CFG_W)'($urandom);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      case (index)
         REG_IMAGE_WIDTH:  size_width  = data[CFG_W-1:0];
         REG_IMAGE_HEIGHT: size_height = data[CFG_W-1:0];
         REG_WEIGHT_TOP:   wt_row[0]   = data[WGT_W-1:0];
         REG_WEIGHT_MID:   wt_row[1]   = data[WGT_W-1:0];
         REG_WEIGHT_BOT:   wt_row[2]   = data[WGT_W-1:0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_size(input int unsigned w, input int unsigned h);
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic write_weights(input logic [WGT_W-1:0] top, input logic [WGT_W-1:0] mid,
                                input logic [WGT_W-1:0] bot);
      write_reg(REG_WEIGHT_TOP, top);
      write_reg(REG_WEIGHT_MID, mid);
      write_reg(REG_WEIGHT_BOT, bot);
   endtask

   function automatic logic [WGT_W-1:0] pick_weight_row();
      case ($urandom_range(0, 4))
         0:       return WGT_W'($urandom);
         1:       return {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)};
         2:       return '0;
         3:       return {WGT_W{1'b1}};
         default: return WEIGHT_RESET;
      endcase
   endfunction

   function automatic pixel_type pattern_pixel(input pattern_type pat);
      pattern_index++;
      case (pat)
         PAT_BLACK:   return 8'd0;
         PAT_WHITE:   return 8'd255;
         PAT_CHECKER: return pattern_index[0] ? 8'd255 : 8'd0;
         PAT_RAMP:    return pixel_type'(pattern_index * 7);
         default:     return pixel_type'($urandom);
      endcase
   endfunction

   // Stream the rest of the current frame: pixels until the last row is in,
   // then drains until the frame_end output is due. With noise on, sprinkle
   // in items that the block must ignore.
   task automatic finish_frame(input pattern_type pat, input bit noise);
      frame_closed = 1'b0;
      while (in_row < active_height()) begin
         if (noise && $urandom_range(0, 15) == 0)
            send_item(FUNC_DRAIN, pixel_type'($urandom));
         send_item(FUNC_PIXEL, pattern_pixel(pat));
      end
      while (!frame_closed) begin
         if (noise && $urandom_range(0, 7) == 0)
            send_item(FUNC_PIXEL, pixel_type'($urandom));
         send_item(FUNC_DRAIN, pixel_type'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset weights give a plain box blur; corner values, stray drain inside
   // the frame, stray pixel after the frame is complete, drain after close.
   task automatic test_reset_weights();
      pixel_type corner_px [6];
      corner_px = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd1};
      write_size(3, 2);
      frame_closed = 1'b0;
      send_item(FUNC_DRAIN, 8'hA5);
      foreach (corner_px[i]) send_item(FUNC_PIXEL, corner_px[i]);
      send_item(FUNC_PIXEL, 8'h5A);
      finish_frame(PAT_RANDOM, 1'b0);
      send_item(FUNC_DRAIN, 8'hFF);
      wait_drained();
   endtask

   // All weights zero: every output must be zero.
   task automatic test_zero_weight_sum();
      write_weights('0, '0, '0);
      write_size(2, 1);
      finish_frame(PAT_WHITE, 1'b0);
      wait_drained();
   endtask

   // Shrink the width while the first row is partly in: the next pixel wraps.
   task automatic test_width_wrap();
      write_weights(24'h030201, 24'h060504, 24'h090807);
      write_size(6, 2);
      frame_closed = 1'b0;
      repeat (4) send_item(FUNC_PIXEL, pixel_type'($urandom));
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(2));
      finish_frame(PAT_RAMP, 1'b0);
      wait_drained();
   endtask

   // Widest and tallest frames, out-of-range sizes, heaviest weights.
   task automatic test_config_extremes();
      write_weights({WGT_W{1'b1}}, {WGT_W{1'b1}}, {WGT_W{1'b1}});
      write_size(2047, 1);
      finish_frame(PAT_RANDOM, 1'b0);
      wait_drained();
      write_weights(pick_weight_row(), pick_weight_row(), pick_weight_row());
      write_size(1, 2047);
      finish_frame(PAT_CHECKER, 1'b0);
      wait_drained();
      write_weights(WGT_W'($urandom), WGT_W'($urandom), WGT_W'($urandom));
      write_size(0, 0);
      finish_frame(PAT_WHITE, 1'b0);
      wait_drained();
      write_size(1024, 2);
      finish_frame(PAT_RAMP, 1'b0);
      wait_drained();
   endtask

   // Hold the receiver off for a long stretch while the sender pushes with
   // no gaps, so the block fills and raises full.
   task automatic test_backpressure();
      write_weights(24'h010201, 24'h020402, 24'h010201);
      write_size(16, 8);
      pace_enabled     = 1'b0;
      pop_hold_request = 400;
      finish_frame(PAT_RANDOM, 1'b0);
      pace_enabled = 1'b1;
      wait_drained();
   endtask

   // Pause the sender mid-frame until every owed output is out, then resume.
   task automatic test_sender_pause();
      write_size(7, 5);
      frame_closed = 1'b0;
      repeat (17) send_item(FUNC_PIXEL, pixel_type'($urandom));
      wait_drained();
      finish_frame(PAT_RANDOM, 1'b1);
      wait_drained();
   endtask

   // Well-formed frames of random small size, weights and content; some
   // frames carry stray items, some follow back to back without a pause.
   task automatic test_random_frames();
      int unsigned start_count, w, h;
      start_count = accepted_pixels;
      while (accepted_pixels < start_count + RANDOM_PIXELS) begin
         if ($urandom_range(0, 1) == 0) begin
            wait_drained();
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 19) == 0) w = 0;
            if ($urandom_range(0, 19) == 0) h = 0;
            write_size(w, h);
            write_weights(pick_weight_row(), pick_weight_row(), pick_weight_row());
         end
         finish_frame(pattern_type'($urandom_range(0, 4)), $urandom_range(0, 3) == 0);
      end
   endtask

   // ------------------------------------------------------------------
   // Result checking: compare each accepted output with the oldest owed one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : output_check
      blur_out_type owed;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected output pixel_out=%0d row_end=%0b frame_end=%0b",
                     $time, rsp_pixel_out, rsp_row_end, rsp_frame_end);
            fault_count++;
         end else begin
            owed = pending_outputs.pop_front();
            if (rsp_pixel_out !== owed.pixel) begin
               $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                        $time, owed.pixel, rsp_pixel_out);
               fault_count++;
            end
            if (rsp_row_end !== owed.row_end) begin
               $display("%0t: row_end mismatch, expected %0b, got %0b",
                        $time, owed.row_end, rsp_row_end);
               fault_count++;
            end
            if (rsp_frame_end !== owed.frame_end) begin
               $display("%0t: frame_end mismatch, expected %0b, got %0b",
                        $time, owed.frame_end, rsp_frame_end);
               fault_count++;
            end
         end
      end
   end

   // Receiver: stall on a changing pattern, or hold pop low for a requested
   // number of cycles counted here.
   initial begin : output_sink
      int unsigned hold_left, mode_left, phase;
      sink_mode_type mode;
      hold_left = 0;
      mode_left = 0;
      phase     = 0;
      mode      = SINK_FREE;
      forever begin
         @(posedge clock);
         if (pop_hold_request != 0) begin
            hold_left        = pop_hold_request;
            pop_hold_request = 0;
         end
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         phase++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (mode)
               SINK_COIN:     rsp_pop <= 1'($urandom_range(0, 1));
               SINK_PERIODIC: rsp_pop <= (phase % 8) >= 3;
               SINK_SPARSE:   rsp_pop <= ($urandom_range(0, 5) == 0);
               default:       rsp_pop <= 1'b1;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      fault_count      = 0;
      accepted_pixels  = 0;
      pattern_index    = 0;
      burst_left       = 0;
      pop_hold_request = 0;
      frame_closed     = 1'b0;
      blur_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_weights();
      test_zero_weight_sum();
      test_width_wrap();
      test_config_extremes();
      test_backpressure();
      test_sender_pause();
      test_random_frames();
      wait_drained();

      if (fault_count == 0) begin
         $display("box_blur_3x3_stream_tb: done, clean");
      end else begin
         $display("box_blur_3x3_stream_tb: done, errors");
      end
      $finish;
   end

   // Watchdog: stop a hung run well past the slowest correct one.
   initial begin
      #8_000_000;
      $display("box_blur_3x3_stream_tb: done, errors");
      $finish;
   end

endmodule

FILE: box_blur_3x3_stream.f
hdl/bbs_pkg.sv
hdl/bbs_ram.sv
hdl/bbs_front.sv
hdl/bbs_queue.sv
hdl/bbs_back.sv
hdl/box_blur_3x3_stream.sv
tb/box_blur_3x3_stream_tb.sv
